// ===== design/ansi_color_text_cell_writer_defines.svh =====
// Assertion macros for the ANSI color text cell writer.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ANSI_COLOR_TEXT_CELL_WRITER_DEFINES_SVH
`define ANSI_COLOR_TEXT_CELL_WRITER_DEFINES_SVH
`ifndef SYNTHESIS
`define ACCTW_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ACCTW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ACCTW_ASSERT(lbl, clk, rst, prop, msg)
`define ACCTW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== design/acctw_pkg.sv =====
// Shared types, constants and SGR decode helpers for the ANSI color text cell writer.
// No dependencies.
`default_nettype none
package acctw_pkg;

   typedef enum logic [1:0] {
      MODE_GROUND,
      MODE_ESC,
      MODE_PARAMS
   } mode_type;

   typedef enum logic {
      CSR_INVERT  = 1'b0,
      CSR_COLUMNS = 1'b1
   } csr_index_type;

   localparam logic [7:0] CH_ESC      = 8'h1B;
   localparam logic [7:0] CH_NL       = 8'h0A;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_M        = 8'h6D;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_SPACE    = 8'h20;

   localparam logic [7:0] DIGIT_MAX   = 8'd255;

   localparam logic [7:0] SGR_FG_LO   = 8'd30;
   localparam logic [7:0] SGR_FG_HI   = 8'd40;
   localparam logic [7:0] SGR_BG_LO   = 8'd40;
   localparam logic [7:0] SGR_BG_HI   = 8'd50;
   localparam logic [7:0] SGR_BFG_LO  = 8'd90;
   localparam logic [7:0] SGR_BFG_HI  = 8'd100;
   localparam logic [7:0] SGR_BFG_OFS = 8'd9;

   localparam logic [4:0] FG_NORMAL   = 5'd7;
   localparam logic [3:0] BG_NORMAL   = 4'd0;
   localparam logic [4:0] FG_INVERTED = 5'd0;
   localparam logic [3:0] BG_INVERTED = 4'd7;
   localparam logic [7:0] COLUMNS_RESET = 8'd80;

   typedef struct packed {
      logic       fg_hit;
      logic       fg_dflt;
      logic [4:0] fg_val;
      logic       bg_hit;
      logic       bg_dflt;
      logic [3:0] bg_val;
   } sgr_type;

   typedef struct packed {
      logic    print;
      logic    newline;
      logic    apply;
      sgr_type sgr;
   } ev_type;

   typedef struct packed {
      logic          en;
      csr_index_type index;
      logic [7:0]    data;
   } csr_wr_type;

   typedef struct packed {
      logic [15:0] row;
      logic [7:0]  column;
      logic [6:0]  char_code;
      logic [4:0]  fg_index;
      logic [3:0]  bg_index;
   } cell_type;

   function automatic sgr_type sgr_decode(logic [7:0] code);
      sgr_type s;
      s = '0;
      if (code == 8'd0) begin
         s.fg_hit  = 1'b1;
         s.fg_dflt = 1'b1;
         s.bg_hit  = 1'b1;
         s.bg_dflt = 1'b1;
      end else if (code >= SGR_FG_LO && code < SGR_FG_HI) begin
         s.fg_hit = 1'b1;
         s.fg_val = 5'(code - SGR_FG_LO);
      end else if (code >= SGR_BG_LO && code < SGR_BG_HI) begin
         s.bg_hit = 1'b1;
         s.bg_val = 4'(code - SGR_BG_LO);
      end else if (code >= SGR_BFG_LO && code < SGR_BFG_HI) begin
         s.fg_hit = 1'b1;
         s.fg_val = 5'(code - SGR_BFG_LO + SGR_BFG_OFS);
      end
      return s;
   endfunction

   // earlier parameter wins: a later one only fills the fields that the earlier one left unset
   function automatic sgr_type sgr_merge(sgr_type first, sgr_type later);
      sgr_type r;
      r = first;
      if (!first.fg_hit) begin
         r.fg_hit  = later.fg_hit;
         r.fg_dflt = later.fg_dflt;
         r.fg_val  = later.fg_val;
      end
      if (!first.bg_hit) begin
         r.bg_hit  = later.bg_hit;
         r.bg_dflt = later.bg_dflt;
         r.bg_val  = later.bg_val;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== design/acctw_parser.sv =====
// Escape sequence parser: tracks plain text, ESC and parameter list modes.
// Depends on acctw_pkg.
`default_nettype none
module acctw_parser #(
   parameter int MAX_PARAMS = 5
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             fire,
   input  wire logic [7:0]       text_byte,
   output acctw_pkg::ev_type     ev
);
   import acctw_pkg::*;

   localparam int CW = $clog2(MAX_PARAMS + 1);
   localparam logic [CW-1:0] CNT_LAST = CW'(MAX_PARAMS);

   mode_type      mode_ff, mode_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [7:0]    acc_ff, acc_in;
   sgr_type       pend_ff, pend_in;

   logic          is_digit;
   logic [11:0]   acc_ext;
   logic [11:0]   prod;
   logic [7:0]    acc_sat;
   logic [CW-1:0] cnt_inc;
   sgr_type       merged;

   always_comb begin
      is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
      acc_ext  = {4'd0, acc_ff};
      prod     = (acc_ext << 3) + (acc_ext << 1) + {8'd0, 4'(text_byte - CH_ZERO)};
      acc_sat  = (prod > {4'd0, DIGIT_MAX}) ? DIGIT_MAX : prod[7:0];
      cnt_inc  = cnt_ff + CW'(1);
      merged   = sgr_merge(pend_ff, sgr_decode(acc_ff));
   end

   always_comb begin
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      pend_in = pend_ff;
      ev      = '0;
      unique case (mode_ff)
         MODE_GROUND: begin
            if (text_byte == CH_ESC) begin
               mode_in = MODE_ESC;
            end else if (text_byte == CH_NL) begin
               ev.newline = 1'b1;
            end else if (!text_byte[7] && text_byte >= CH_SPACE) begin
               ev.print = 1'b1;
            end
         end
         MODE_ESC: begin
            if (text_byte == CH_LBRACKET) begin
               mode_in = MODE_PARAMS;
               cnt_in  = '0;
               acc_in  = '0;
               pend_in = '0;
            end else begin
               mode_in = MODE_GROUND;
            end
         end
         MODE_PARAMS: begin
            if (is_digit) begin
               acc_in = acc_sat;
            end else if (text_byte == CH_SEMI) begin
               pend_in = merged;
               cnt_in  = cnt_inc;
               acc_in  = '0;
               if (cnt_inc == CNT_LAST) begin
                  mode_in = MODE_GROUND;
               end
            end else begin
               if (text_byte == CH_M) begin
                  ev.apply = 1'b1;
                  ev.sgr   = merged;
               end
               mode_in = MODE_GROUND;
               cnt_in  = '0;
               acc_in  = '0;
            end
         end
         default: begin
            mode_in = MODE_GROUND;
         end
      endcase
      if (!fire) begin
         ev = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_GROUND;
         cnt_ff  <= '0;
         acc_ff  <= '0;
         pend_ff <= '0;
      end else if (fire) begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
         acc_ff  <= acc_in;
         pend_ff <= pend_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/acctw_cell_gen.sv =====
// Cursor, color and configuration registers; builds the cell word for a printable byte.
// Depends on acctw_pkg.
`default_nettype none
module acctw_cell_gen (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  acctw_pkg::ev_type         ev,
   input  wire logic [6:0]           char_code,
   input  acctw_pkg::csr_wr_type     csr,
   output logic                      emit,
   output acctw_pkg::cell_type       word
);
   import acctw_pkg::*;

   logic        invert_ff, invert_in;
   logic [7:0]  cols_ff, cols_in;
   logic [15:0] row_ff, row_in;
   logic [7:0]  col_ff, col_in;
   logic [4:0]  fg_ff, fg_in;
   logic [3:0]  bg_ff, bg_in;
   logic [4:0]  dflt_fg;
   logic [3:0]  dflt_bg;

   always_comb begin
      dflt_fg = invert_ff ? FG_INVERTED : FG_NORMAL;
      dflt_bg = invert_ff ? BG_INVERTED : BG_NORMAL;
      emit    = fire && ev.print && (col_ff < cols_ff);

      word.row       = row_ff;
      word.column    = col_ff;
      word.char_code = char_code;
      word.fg_index  = fg_ff;
      word.bg_index  = bg_ff;

      invert_in = invert_ff;
      cols_in   = cols_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      fg_in     = fg_ff;
      bg_in     = bg_ff;

      if (csr.en) begin
         unique case (csr.index)
            CSR_INVERT: begin
               invert_in = csr.data[0];
               fg_in     = csr.data[0] ? FG_INVERTED : FG_NORMAL;
               bg_in     = csr.data[0] ? BG_INVERTED : BG_NORMAL;
            end
            CSR_COLUMNS: begin
               cols_in = csr.data;
            end
            default: begin
               cols_in = cols_ff;
            end
         endcase
      end else begin
         if (ev.newline) begin
            row_in = row_ff + 16'd1;
            col_in = '0;
         end
         if (emit) begin
            col_in = col_ff + 8'd1;
         end
         if (ev.apply && ev.sgr.fg_hit) begin
            fg_in = ev.sgr.fg_dflt ? dflt_fg : ev.sgr.fg_val;
         end
         if (ev.apply && ev.sgr.bg_hit) begin
            bg_in = ev.sgr.bg_dflt ? dflt_bg : ev.sgr.bg_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff <= 1'b0;
         cols_ff   <= COLUMNS_RESET;
         row_ff    <= '0;
         col_ff    <= '0;
         fg_ff     <= FG_NORMAL;
         bg_ff     <= BG_NORMAL;
      end else begin
         invert_ff <= invert_in;
         cols_ff   <= cols_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         fg_ff     <= fg_in;
         bg_ff     <= bg_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/ansi_color_text_cell_writer.sv =====
// Top level of the ANSI color text cell writer: input register, parser, cell generator,
// result register. Depends on acctw_pkg, acctw_parser, acctw_cell_gen and the defines header.
//
// Takes one terminal byte per clock for as long as rsp_ready stays high and returns one
// cell word (row, column, character, foreground and background palette index) per visible
// printable byte. Each byte passes through the input register and then the result register
// before its cell word appears on rsp_. Parser and cursor state update once per accepted
// byte, which sets that rate. Bytes that produce no cell (controls, escape sequences,
// clipped text) still occupy the input register. Configuration writes on csr_ are always
// taken at once; write them only while the block is quiet.
// MAX_PARAMS (1..16) bounds the SGR parameter list.
`default_nettype none
module ansi_color_text_cell_writer #(
   parameter int MAX_PARAMS = 5
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_text_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_row,
   output logic [7:0]       rsp_column,
   output logic [6:0]       rsp_char_code,
   output logic [4:0]       rsp_fg_index,
   output logic [3:0]       rsp_bg_index,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata
);
   import acctw_pkg::*;
`include "ansi_color_text_cell_writer_defines.svh"

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff, s1_byte_in;
   logic       out_valid_ff, out_valid_in;
   cell_type   out_cell_ff, out_cell_in;

   logic       out_free;
   logic       s1_fire;
   logic       req_fire;
   logic       emit;
   ev_type     ev;
   cell_type   word;
   csr_wr_type csr;

   always_comb begin
      out_free  = !out_valid_ff || rsp_ready;
      s1_fire   = s1_valid_ff && out_free;
      req_ready = !s1_valid_ff || s1_fire;
      req_fire  = req_valid && req_ready;
      csr_ready = 1'b1;

      csr.en    = csr_valid;
      csr.index = csr_index_type'(csr_index);
      csr.data  = csr_wdata;

      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_text_byte;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_cell_in  = out_cell_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_cell_in  = word;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end

      rsp_valid     = out_valid_ff;
      rsp_row       = out_cell_ff.row;
      rsp_column    = out_cell_ff.column;
      rsp_char_code = out_cell_ff.char_code;
      rsp_fg_index  = out_cell_ff.fg_index;
      rsp_bg_index  = out_cell_ff.bg_index;
   end

   acctw_parser #(
      .MAX_PARAMS(MAX_PARAMS)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .fire     (s1_fire),
      .text_byte(s1_byte_ff),
      .ev       (ev)
   );

   acctw_cell_gen u_cell_gen (
      .clock    (clock),
      .reset    (reset),
      .fire     (s1_fire),
      .ev       (ev),
      .char_code(s1_byte_ff[6:0]),
      .csr      (csr),
      .emit     (emit),
      .word     (word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_byte_ff  <= s1_byte_in;
      out_cell_ff <= out_cell_in;
   end

   `ACCTW_ASSERT(a_char_printable, clock, reset, rsp_valid |-> (rsp_char_code >= 7'h20), "non-printable char in cell word")
   `ACCTW_ASSERT(a_color_range, clock, reset, rsp_valid |-> ((rsp_fg_index <= 5'd18) && (rsp_bg_index <= 4'd9)), "palette index out of range")
   `ACCTW_ASSERT(a_ready_blocked, clock, reset, !req_ready |-> (s1_valid_ff && out_valid_ff && !rsp_ready), "input stalled without cause")
   `ACCTW_ASSERT_NEXT(a_emit_lands, clock, reset, emit, rsp_valid, "emitted cell not presented")
   `ACCTW_ASSERT_NEXT(a_no_phantom, clock, reset, (!emit && rsp_valid && rsp_ready), !rsp_valid, "cell word repeated or invented")

endmodule
`default_nettype wire
